[rtl/ptp_pkg.sv]
package ptp_pkg;

    localparam int COORD_W = 32;
    localparam int PUSH_W  = 31;
    localparam logic [PUSH_W-1:0] PUSH_RESET = PUSH_W'(6554);

    // exact integer widths of the intermediates
    localparam int E_W    = COORD_W + 1;
    localparam int N_W    = 2 * E_W + 2;
    localparam int NN_W   = 2 * N_W;
    localparam int NRP_W  = N_W + E_W + 3;
    localparam int PR_W   = 25;
    localparam int PP_W   = COORD_W + 1;
    localparam int T_W    = PP_W + 1;
    localparam int CR_W   = 2 * T_W + 4;
    localparam int S_W    = PUSH_W + 16 + 4;

    // shared multiplier, one 8-bit digit of y per cycle
    localparam int MUL_XW    = NN_W;
    localparam int MUL_YW    = 72;
    localparam int DIG_W     = 8;
    localparam int MUL_STEPS = MUL_YW / DIG_W;
    localparam int MCNT_W    = $clog2(MUL_STEPS);
    localparam int PROD_W    = MUL_XW + MUL_YW;

    // divider
    localparam int DVD_W  = 168;
    localparam int Q_W    = 40;
    localparam int DCNT_W = $clog2(Q_W);

    localparam int PC_W    = 6;
    localparam int PC_LAST = 44;

    typedef struct packed {
        logic               op;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
        logic               last_item;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               moved;
    } out_beat_t;

    typedef enum logic [2:0] {
        XS_E1, XS_N, XS_NRP, XS_PR, XS_T, XS_CR
    } xsel_t;

    typedef enum logic [2:0] {
        YS_E2, YS_N, YS_R, YS_PR, YS_T
    } ysel_t;

    typedef enum logic [2:0] {
        DS_NONE, DS_N, DS_NN, DS_NRP, DS_DIV, DS_S, DS_CR, DS_DOT
    } dst_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_MUL, ST_CHECK, ST_DIV_START, ST_DIV, ST_DIV_CHECK, ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        xsel_t      x_sel;
        logic [1:0] x_idx;
        ysel_t      y_sel;
        logic [1:0] y_idx;
        logic [1:0] vk;
        logic       clr;
        logic       sub;
        dst_t       dst;
        logic [1:0] dst_idx;
        logic       last;
    } uop_t;

    typedef struct packed {
        logic in_load;
        logic point_load;
        logic mul_start;
        logic div_start;
        logic commit;
        logic out_load;
        uop_t uop;
    } ptp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic nn_zero;
        logic nrp_neg;
        logic pr_far;
        logic s_ge;
        logic dot_neg;
    } ptp_stat_t;

    // one term of a cross product component; second term subtracts
    function automatic uop_t cross_set(input uop_t u_in, input logic [2:0] t);
        uop_t       u;
        logic [1:0] j;
        logic [1:0] l;
        u = u_in;
        case (t[2:1])
            2'd0: begin j = 2'd1; l = 2'd2; end
            2'd1: begin j = 2'd2; l = 2'd0; end
            default: begin j = 2'd0; l = 2'd1; end
        endcase
        if (!t[0]) begin
            u.x_idx = j;
            u.y_idx = l;
            u.clr   = 1'b1;
        end else begin
            u.x_idx = l;
            u.y_idx = j;
            u.sub   = 1'b1;
        end
        u.dst_idx = t[2:1];
        return u;
    endfunction

    function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
        uop_t          u;
        logic [PC_W-1:0] rel;
        logic [PC_W-1:0] j;
        logic [1:0]      k;
        u   = '0;
        rel = '0;
        j   = '0;
        k   = '0;
        if (pc < PC_W'(6)) begin
            u.x_sel = XS_E1;
            u.y_sel = YS_E2;
            u = cross_set(u, pc[2:0]);
            u.dst = pc[0] ? DS_N : DS_NONE;
        end else if (pc < PC_W'(9)) begin
            rel = pc - PC_W'(6);
            u.x_sel = XS_N;
            u.y_sel = YS_N;
            u.x_idx = rel[1:0];
            u.y_idx = rel[1:0];
            u.clr   = (rel == '0);
            u.dst   = (rel == PC_W'(2)) ? DS_NN : DS_NONE;
        end else if (pc < PC_W'(12)) begin
            rel = pc - PC_W'(9);
            u.x_sel = XS_N;
            u.y_sel = YS_R;
            u.x_idx = rel[1:0];
            u.y_idx = rel[1:0];
            u.clr   = (rel == '0);
            u.dst   = (rel == PC_W'(2)) ? DS_NRP : DS_NONE;
        end else if (pc < PC_W'(15)) begin
            rel = pc - PC_W'(12);
            u.x_sel   = XS_NRP;
            u.y_sel   = YS_N;
            u.y_idx   = rel[1:0];
            u.clr     = 1'b1;
            u.dst     = DS_DIV;
            u.dst_idx = rel[1:0];
        end else if (pc < PC_W'(18)) begin
            rel = pc - PC_W'(15);
            u.x_sel = XS_PR;
            u.y_sel = YS_PR;
            u.x_idx = rel[1:0];
            u.y_idx = rel[1:0];
            u.clr   = (rel == '0);
            u.dst   = (rel == PC_W'(2)) ? DS_S : DS_NONE;
        end else begin
            rel = pc - PC_W'(18);
            if (rel < PC_W'(9)) begin
                k = 2'd0;
                j = rel;
            end else if (rel < PC_W'(18)) begin
                k = 2'd1;
                j = rel - PC_W'(9);
            end else begin
                k = 2'd2;
                j = rel - PC_W'(18);
            end
            u.vk = k;
            if (j < PC_W'(6)) begin
                u.x_sel = XS_T;
                u.y_sel = YS_T;
                u = cross_set(u, j[2:0]);
                u.dst = j[0] ? DS_CR : DS_NONE;
            end else begin
                rel = j - PC_W'(6);
                u.x_sel = XS_CR;
                u.y_sel = YS_N;
                u.x_idx = rel[1:0];
                u.y_idx = rel[1:0];
                u.clr   = (rel == '0);
                u.dst   = (rel == PC_W'(2)) ? DS_DOT : DS_NONE;
                u.last  = (pc == PC_W'(PC_LAST));
            end
        end
        return u;
    endfunction

endpackage

[rtl/ptp_mul.sv]
module ptp_mul
    import ptp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [MUL_XW-1:0] x,
    input  logic signed [MUL_YW-1:0] y,
    output logic signed [PROD_W-1:0] prod,
    output logic                     done
);

    logic signed [MUL_XW-1:0] x_reg;
    logic        [MUL_YW-1:0] y_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic        [MCNT_W-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [DIG_W:0]    dig;
    logic signed [MUL_XW+DIG_W:0] partial;
    logic                     first;

    // MSB digit first; top digit carries the sign
    assign first = (cnt_reg == '0);
    assign dig   = first ? $signed({y_reg[MUL_YW-1], y_reg[MUL_YW-1 -: DIG_W]})
                         : $signed({1'b0, y_reg[MUL_YW-1 -: DIG_W]});
    assign partial = x_reg * dig;
    assign prod_next = first ? PROD_W'(partial)
                             : (prod_reg <<< DIG_W) + PROD_W'(partial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= x;
                y_reg    <= y;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                prod_reg <= prod_next;
                y_reg    <= y_reg << DIG_W;
                if (cnt_reg == MCNT_W'(MUL_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign prod = prod_reg;
    assign done = done_reg;

endmodule

[rtl/ptp_div.sv]
module ptp_div
    import ptp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] num,
    input  logic        [NN_W-1:0]  den,
    output logic        [Q_W-1:0]   q,
    output logic                    neg,
    output logic                    done
);

    logic [DVD_W-1:0]  mag;
    logic [NN_W-1:0]   rem_reg;
    logic [Q_W-1:0]    dq_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [NN_W:0]     t;
    logic [NN_W:0]     diff;
    logic              ge;

    assign mag  = num[DVD_W-1] ? DVD_W'(-num) : DVD_W'(num);
    assign t    = {rem_reg, dq_reg[Q_W-1]};
    assign ge   = (t >= {1'b0, den});
    assign diff = t - {1'b0, den};

    // quotient is known to fit Q_W bits, so the top part seeds the remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                neg_reg  <= num[DVD_W-1];
                rem_reg  <= NN_W'(mag[DVD_W-1:Q_W]);
                dq_reg   <= mag[Q_W-1:0];
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[NN_W-1:0] : t[NN_W-1:0];
                dq_reg  <= {dq_reg[Q_W-2:0], ge};
                if (cnt_reg == DCNT_W'(Q_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign q    = dq_reg;
    assign neg  = neg_reg;
    assign done = done_reg;

endmodule

[rtl/ptp_dp.sv]
module ptp_dp
    import ptp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  in_beat_t          s_data,
    input  logic              cfg_valid,
    input  logic [PUSH_W-1:0] cfg_data,
    input  ptp_cmd_t          cmd,
    output ptp_stat_t         stat,
    output out_beat_t         m_data
);

    uop_t u;

    logic signed [COORD_W-1:0] vtx_reg [3][3];
    logic signed [COORD_W-1:0] p_reg [3];
    logic                      pushed_reg;
    logic [PUSH_W-1:0]         push_reg;
    logic signed [N_W-1:0]     n_reg [3];
    logic        [NN_W-1:0]    nn_reg;
    logic signed [NRP_W-1:0]   nrp_reg;
    logic signed [PR_W-1:0]    pr_reg [3];
    logic                      pr_far_reg;
    logic signed [CR_W-1:0]    cr_reg [3];
    logic signed [PROD_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0]  acc_next;
    logic signed [PROD_W-1:0]  acc_base;
    out_beat_t                 out_reg;

    logic signed [E_W-1:0]  e1 [3];
    logic signed [E_W-1:0]  e2 [3];
    logic signed [E_W-1:0]  r [3];
    logic signed [PP_W-1:0] pp [3];
    logic signed [COORD_W-1:0] pp_sat [3];
    logic [1:0]             vk1;
    logic signed [T_W-1:0]  tx;
    logic signed [T_W-1:0]  ty;
    logic signed [MUL_XW-1:0] xv;
    logic signed [MUL_YW-1:0] yv;

    logic signed [PROD_W-1:0] prod;
    logic                     mul_done;
    logic [Q_W-1:0]           q;
    logic                     q_neg;
    logic                     div_done;
    logic signed [PR_W-1:0]   q_mag;

    assign u = cmd.uop;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1[i] = E_W'(vtx_reg[1][i]) - E_W'(vtx_reg[0][i]);
            e2[i] = E_W'(vtx_reg[2][i]) - E_W'(vtx_reg[0][i]);
            r[i]  = E_W'(p_reg[i]) - E_W'(vtx_reg[0][i]);
            pp[i] = PP_W'(p_reg[i]) - PP_W'(pr_reg[i]);
            if (pp[i][PP_W-1] != pp[i][PP_W-2]) begin
                pp_sat[i] = pp[i][PP_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                          : {1'b0, {(COORD_W-1){1'b1}}};
            end else begin
                pp_sat[i] = pp[i][COORD_W-1:0];
            end
        end
    end

    assign vk1 = (u.vk == 2'd2) ? 2'd0 : u.vk + 2'd1;
    assign tx  = T_W'(vtx_reg[u.vk][u.x_idx]) - T_W'(pp[u.x_idx]);
    assign ty  = T_W'(vtx_reg[vk1][u.y_idx]) - T_W'(pp[u.y_idx]);

    always_comb begin
        case (u.x_sel)
            XS_E1:   xv = MUL_XW'(e1[u.x_idx]);
            XS_N:    xv = MUL_XW'(n_reg[u.x_idx]);
            XS_NRP:  xv = MUL_XW'(nrp_reg);
            XS_PR:   xv = MUL_XW'(pr_reg[u.x_idx]);
            XS_T:    xv = MUL_XW'(tx);
            XS_CR:   xv = MUL_XW'(cr_reg[u.x_idx]);
            default: xv = '0;
        endcase
        case (u.y_sel)
            YS_E2:   yv = MUL_YW'(e2[u.y_idx]);
            YS_N:    yv = MUL_YW'(n_reg[u.y_idx]);
            YS_R:    yv = MUL_YW'(r[u.y_idx]);
            YS_PR:   yv = MUL_YW'(pr_reg[u.y_idx]);
            YS_T:    yv = MUL_YW'(ty);
            default: yv = '0;
        endcase
    end

    ptp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .x       (xv),
        .y       (yv),
        .prod    (prod),
        .done    (mul_done)
    );

    ptp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (acc_reg[DVD_W-1:0]),
        .den     (nn_reg),
        .q       (q),
        .neg     (q_neg),
        .done    (div_done)
    );

    assign acc_base = u.clr ? '0 : acc_reg;
    assign acc_next = u.sub ? acc_base - prod : acc_base + prod;
    assign q_mag    = $signed({1'b0, q[PR_W-2:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            push_reg   <= PUSH_RESET;
            pushed_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                push_reg <= cfg_data;
            end
            if (cmd.point_load) begin
                p_reg[0]   <= s_data.a_x;
                p_reg[1]   <= s_data.a_y;
                p_reg[2]   <= s_data.a_z;
                pushed_reg <= 1'b0;
            end else if (cmd.commit) begin
                for (int i = 0; i < 3; i++) begin
                    p_reg[i] <= pp_sat[i];
                end
                pushed_reg <= 1'b1;
            end else if (cmd.out_load) begin
                pushed_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            vtx_reg[0][0] <= s_data.a_x;
            vtx_reg[0][1] <= s_data.a_y;
            vtx_reg[0][2] <= s_data.a_z;
            vtx_reg[1][0] <= s_data.b_x;
            vtx_reg[1][1] <= s_data.b_y;
            vtx_reg[1][2] <= s_data.b_z;
            vtx_reg[2][0] <= s_data.c_x;
            vtx_reg[2][1] <= s_data.c_y;
            vtx_reg[2][2] <= s_data.c_z;
        end
        if (mul_done) begin
            acc_reg <= acc_next;
            case (u.dst)
                DS_N:    n_reg[u.dst_idx]  <= acc_next[N_W-1:0];
                DS_NN:   nn_reg            <= acc_next[NN_W-1:0];
                DS_NRP:  nrp_reg           <= acc_next[NRP_W-1:0];
                DS_CR:   cr_reg[u.dst_idx] <= acc_next[CR_W-1:0];
                default: ;
            endcase
        end
        if (div_done) begin
            pr_reg[u.dst_idx] <= q_neg ? -q_mag : q_mag;
            pr_far_reg        <= |q[Q_W-1:PR_W-1];
        end
        if (cmd.out_load) begin
            out_reg.out_x <= p_reg[0];
            out_reg.out_y <= p_reg[1];
            out_reg.out_z <= p_reg[2];
            out_reg.moved <= pushed_reg;
        end
    end

    assign stat.mul_done = mul_done;
    assign stat.div_done = div_done;
    assign stat.nn_zero  = (nn_reg == '0);
    assign stat.nrp_neg  = nrp_reg[NRP_W-1];
    assign stat.pr_far   = pr_far_reg;
    assign stat.s_ge     = (acc_reg[S_W-1:0] >= {4'b0, push_reg, 16'b0});
    assign stat.dot_neg  = acc_reg[PROD_W-1];
    assign m_data        = out_reg;

endmodule

[rtl/ptp_ctrl.sv]
module ptp_ctrl
    import ptp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      in_op,
    input  logic      in_last,
    output logic      m_valid,
    input  logic      m_ready,
    input  ptp_stat_t stat,
    output ptp_cmd_t  cmd
);

    ctrl_state_t     state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            last_reg, last_next;
    logic            m_valid_reg, m_valid_next;
    uop_t            u;
    logic            abort;

    assign u = uop_at(pc_reg);

    always_comb begin
        case (u.dst)
            DS_NN:   abort = stat.nn_zero;
            DS_NRP:  abort = !stat.nrp_neg;
            DS_S:    abort = stat.s_ge;
            DS_DOT:  abort = stat.dot_neg || u.last;
            default: abort = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_next  = in_last;
                    pc_next    = '0;
                    state_next = in_op ? ST_START : ST_FIN;
                end
            end
            ST_START: state_next = ST_MUL;
            ST_MUL: begin
                if (stat.mul_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (abort) begin
                    state_next = ST_FIN;
                end else if (u.dst == DS_DIV) begin
                    state_next = ST_DIV_START;
                end else begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_START;
                end
            end
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_DIV_CHECK;
                end
            end
            ST_DIV_CHECK: begin
                if (stat.pr_far) begin
                    state_next = ST_FIN;
                end else begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_START;
                end
            end
            ST_FIN: begin
                if (!last_reg || !m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        cmd.uop = u;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.in_load    = s_valid;
                cmd.point_load = s_valid && !in_op;
            end
            ST_START:     cmd.mul_start = 1'b1;
            ST_CHECK:     cmd.commit = (u.dst == DS_DOT) && u.last && !stat.dot_neg;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_FIN:       cmd.out_load = last_reg && (!m_valid_reg || m_ready);
            default: ;
        endcase
    end

    assign m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_mul_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.mul_done |-> state_reg == ST_MUL)
        else $error("multiplier finished outside ST_MUL");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside ST_DIV");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid_reg || m_ready)
        else $error("result overwritten while stalled");

    a_commit_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> state_reg == ST_FIN)
        else $error("commit not followed by finish");

endmodule

[rtl/point_triangle_pushout.sv]
// Point against triangle mesh push-out, Q16.16 coordinates.
// Input channel s_valid/s_ready/s_data: a beat with op=0 loads the start point from
// the a fields; a beat with op=1 is one triangle (a, b, c). last_item closes the mesh.
// After the beat marked last_item one result beat leaves on m_valid/m_ready/m_data:
// the resolved point and whether any triangle moved it.
// cfg_valid/cfg_ready/cfg_data writes the squared push distance limit (reset 0.1).
// One beat is processed at a time. A load goes straight to the finish state.
// A triangle runs a 45-step multiply-accumulate program on one shared multiplier
// taking 8 bits of the second operand per cycle, plus three quotient
// divisions; early rejects (degenerate, in front, far, outside) finish
// sooner.
// The result is registered; the next input beat is taken while it waits. If the
// receiver stalls and a second result is ready, the block holds until the first
// is taken. Reset clears the point to the origin and the moved flag, and sets the
// limit back to 0.1.
module point_triangle_pushout
    import ptp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_beat_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_beat_t         m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [PUSH_W-1:0] cfg_data
);

    ptp_cmd_t  cmd;
    ptp_stat_t stat;

    assign cfg_ready = 1'b1;

    ptp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_op   (s_data.op),
        .in_last (s_data.last_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule
